/* hdl/assert_macros.svh */
// assertion macros used by the pixel converter core
// no dependencies; take in with an include of the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent this cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

`endif

/* hdl/hfrgb_pkg.sv */
// types, constants and the half-float decoder for the pixel converter
// no dependencies; used by every module of the block by scoped names
package hfrgb_pkg;

   localparam int Q16_WIDTH  = 24;
   localparam int PROD_WIDTH = 40;
   localparam int SUM_WIDTH  = 41;
   localparam int COL_WIDTH  = 32;

   localparam logic [Q16_WIDTH-1:0] Q16_MAX = 24'hFF_FFFF;
   localparam logic [15:0] W_RED   = 16'd19595;
   localparam logic [15:0] W_GREEN = 16'd38470;
   localparam logic [15:0] W_BLUE  = 16'd7471;

   localparam logic [1:0] BYTES_MONO   = 2'd1;
   localparam logic [1:0] BYTES_COLOUR = 2'd3;
   localparam logic       MONO_RESET   = 1'b1;

   typedef struct packed {
      logic [15:0] red_half;
      logic [15:0] green_half;
      logic [15:0] blue_half;
   } req_type;

   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [7:0] third_byte;
      logic [1:0] byte_count;
   } rsp_type;

   // control that travels with each item down the pipe
   typedef struct packed {
      logic valid;
      logic mono;
   } ctrl_type;

   typedef struct packed {
      logic [Q16_WIDTH-1:0] red;
      logic [Q16_WIDTH-1:0] green;
      logic [Q16_WIDTH-1:0] blue;
   } q16_rgb_type;

   function automatic logic [Q16_WIDTH-1:0] half_to_q16(input logic [15:0] h);
      logic                 sgn;
      logic [4:0]           ex;
      logic [9:0]           man;
      logic [10:0]          sig;
      logic [4:0]           eff;
      logic [Q16_WIDTH-1:0] wide;
      logic [Q16_WIDTH-1:0] res;
      sgn  = h[15];
      ex   = h[14:10];
      man  = h[9:0];
      sig  = (ex == 5'd0) ? {1'b0, man} : {1'b1, man};
      eff  = (ex == 5'd0) ? 5'd1 : ex;
      wide = {13'd0, sig};
      if (ex == 5'd31) begin
         res = ((man != 10'd0) || sgn) ? '0 : Q16_MAX;
      end else if (sgn) begin
         res = '0;
      end else if (eff >= 5'd23) begin
         res = Q16_MAX;
      end else if (eff >= 5'd9) begin
         res = wide << (eff - 5'd9);
      end else begin
         // round to nearest, ties upward
         res = (wide + (24'd1 << (5'd8 - eff))) >> (5'd9 - eff);
      end
      return res;
   endfunction

endpackage

/* hdl/hfrgb_decode.sv */
// stage one: decodes the three half-precision channels to unsigned Q8.16
// depends on hfrgb_pkg
module hfrgb_decode (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    mono,
   input  hfrgb_pkg::req_type      req_data,
   output hfrgb_pkg::ctrl_type     s1_ctrl,
   output hfrgb_pkg::q16_rgb_type  s1_q
);

   hfrgb_pkg::ctrl_type    ctrl_ff, ctrl_in;
   hfrgb_pkg::q16_rgb_type q_ff, q_in;

   always_comb begin
      ctrl_in.valid = accept;
      ctrl_in.mono  = mono;
      q_in.red      = hfrgb_pkg::half_to_q16(req_data.red_half);
      q_in.green    = hfrgb_pkg::half_to_q16(req_data.green_half);
      q_in.blue     = hfrgb_pkg::half_to_q16(req_data.blue_half);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign s1_ctrl = ctrl_ff;
   assign s1_q    = q_ff;

endmodule

/* hdl/hfrgb_mul.sv */
// stage two: weights the channels for luma and scales them by 255 for colour
// depends on hfrgb_pkg
module hfrgb_mul (
   input  logic                                   clock,
   input  logic                                   reset,
   input  hfrgb_pkg::ctrl_type                    s1_ctrl,
   input  hfrgb_pkg::q16_rgb_type                 s1_q,
   output hfrgb_pkg::ctrl_type                    s2_ctrl,
   output logic [hfrgb_pkg::PROD_WIDTH-1:0]       s2_prod_r,
   output logic [hfrgb_pkg::PROD_WIDTH-1:0]       s2_prod_g,
   output logic [hfrgb_pkg::PROD_WIDTH-1:0]       s2_prod_b,
   output logic [hfrgb_pkg::COL_WIDTH-1:0]        s2_col_r,
   output logic [hfrgb_pkg::COL_WIDTH-1:0]        s2_col_g,
   output logic [hfrgb_pkg::COL_WIDTH-1:0]        s2_col_b
);

   localparam logic [hfrgb_pkg::COL_WIDTH-1:0] HALF_LSB = 32'd32768;

   hfrgb_pkg::ctrl_type                ctrl_ff;
   logic [hfrgb_pkg::PROD_WIDTH-1:0]   prod_r_ff, prod_r_in;
   logic [hfrgb_pkg::PROD_WIDTH-1:0]   prod_g_ff, prod_g_in;
   logic [hfrgb_pkg::PROD_WIDTH-1:0]   prod_b_ff, prod_b_in;
   logic [hfrgb_pkg::COL_WIDTH-1:0]    col_r_ff, col_r_in;
   logic [hfrgb_pkg::COL_WIDTH-1:0]    col_g_ff, col_g_in;
   logic [hfrgb_pkg::COL_WIDTH-1:0]    col_b_ff, col_b_in;
   logic [hfrgb_pkg::COL_WIDTH-1:0]    ext_r, ext_g, ext_b;

   always_comb begin
      prod_r_in = {16'd0, s1_q.red}   * {24'd0, hfrgb_pkg::W_RED};
      prod_g_in = {16'd0, s1_q.green} * {24'd0, hfrgb_pkg::W_GREEN};
      prod_b_in = {16'd0, s1_q.blue}  * {24'd0, hfrgb_pkg::W_BLUE};
      ext_r     = {8'd0, s1_q.red};
      ext_g     = {8'd0, s1_q.green};
      ext_b     = {8'd0, s1_q.blue};
      // times 255 as shift and subtract, plus half an lsb of the byte
      col_r_in  = (ext_r << 8) - ext_r + HALF_LSB;
      col_g_in  = (ext_g << 8) - ext_g + HALF_LSB;
      col_b_in  = (ext_b << 8) - ext_b + HALF_LSB;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= s1_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      prod_r_ff <= prod_r_in;
      prod_g_ff <= prod_g_in;
      prod_b_ff <= prod_b_in;
      col_r_ff  <= col_r_in;
      col_g_ff  <= col_g_in;
      col_b_ff  <= col_b_in;
   end

   assign s2_ctrl   = ctrl_ff;
   assign s2_prod_r = prod_r_ff;
   assign s2_prod_g = prod_g_ff;
   assign s2_prod_b = prod_b_ff;
   assign s2_col_r  = col_r_ff;
   assign s2_col_g  = col_g_ff;
   assign s2_col_b  = col_b_ff;

endmodule

/* hdl/hfrgb_round.sv */
// stages three and four: sums luma, scales, rounds, caps and forms the result
// depends on hfrgb_pkg
module hfrgb_round (
   input  logic                                clock,
   input  logic                                reset,
   input  hfrgb_pkg::ctrl_type                 s2_ctrl,
   input  logic [hfrgb_pkg::PROD_WIDTH-1:0]    s2_prod_r,
   input  logic [hfrgb_pkg::PROD_WIDTH-1:0]    s2_prod_g,
   input  logic [hfrgb_pkg::PROD_WIDTH-1:0]    s2_prod_b,
   input  logic [hfrgb_pkg::COL_WIDTH-1:0]     s2_col_r,
   input  logic [hfrgb_pkg::COL_WIDTH-1:0]     s2_col_g,
   input  logic [hfrgb_pkg::COL_WIDTH-1:0]     s2_col_b,
   output logic                                rsp_valid,
   output hfrgb_pkg::rsp_type                  rsp_data
);

   localparam int LUMA_WIDTH = hfrgb_pkg::SUM_WIDTH + 8;
   localparam logic [LUMA_WIDTH-1:0] HALF_LSB = LUMA_WIDTH'(64'h8000_0000);

   hfrgb_pkg::ctrl_type                ctrl3_ff;
   logic [hfrgb_pkg::SUM_WIDTH-1:0]    sum_ff, sum_in;
   logic [7:0]                         byte_r_ff, byte_r_in;
   logic [7:0]                         byte_g_ff, byte_g_in;
   logic [7:0]                         byte_b_ff, byte_b_in;
   logic [LUMA_WIDTH-1:0]              luma_ext, luma_scaled;
   logic [LUMA_WIDTH-33:0]             luma_top;
   logic [7:0]                         grey;
   logic                               rsp_valid_ff;
   hfrgb_pkg::rsp_type                 rsp_ff, rsp_in;

   function automatic logic [7:0] cap_col(input logic [hfrgb_pkg::COL_WIDTH-1:0] c);
      return (c[31:24] != 8'd0) ? 8'hFF : c[23:16];
   endfunction

   // stage three
   always_comb begin
      sum_in    = {1'b0, s2_prod_r} + {1'b0, s2_prod_g} + {1'b0, s2_prod_b};
      byte_r_in = cap_col(s2_col_r);
      byte_g_in = cap_col(s2_col_g);
      byte_b_in = cap_col(s2_col_b);
   end

   // stage four: times 255 by shift and subtract, round, cap, and pick the mono or colour result
   always_comb begin
      luma_ext    = {8'd0, sum_ff};
      luma_scaled = (luma_ext << 8) - luma_ext + HALF_LSB;
      luma_top    = luma_scaled[LUMA_WIDTH-1:32];
      grey        = (luma_top > (LUMA_WIDTH-32)'(255)) ? 8'hFF : luma_top[7:0];
      if (ctrl3_ff.mono) begin
         rsp_in.first_byte  = grey;
         rsp_in.second_byte = 8'd0;
         rsp_in.third_byte  = 8'd0;
         rsp_in.byte_count  = hfrgb_pkg::BYTES_MONO;
      end else begin
         rsp_in.first_byte  = byte_b_ff;
         rsp_in.second_byte = byte_g_ff;
         rsp_in.third_byte  = byte_r_ff;
         rsp_in.byte_count  = hfrgb_pkg::BYTES_COLOUR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl3_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctrl3_ff     <= s2_ctrl;
         rsp_valid_ff <= ctrl3_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      byte_r_ff <= byte_r_in;
      byte_g_ff <= byte_g_in;
      byte_b_ff <= byte_b_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hdl/half_float_rgb_to_gray_or_bgr8_core.sv */
// Pixel converter: three half-precision channels in, one grey byte (BT.601
// luma) or three bytes in B, G, R order out, chosen by csr mono_mode.
//
// Input: an item is taken at a rising edge where start is high and busy is
// low; req_data carries red_half, green_half, blue_half.
// Config: csr_wr_en with csr_wr_data writes mono_mode (reset value 1).
// Write it only while no item is in flight.
// Output: rsp_valid is high for one cycle with rsp_data; it cannot be held
// off, so the receiver must take every item as it appears.
// The result strobe follows the accepting edge through four register stages:
// decode, multiply, luma sum and colour cap, luma scale and output register.
// Throughput: one pixel per clock whenever busy is low; the pipeline never stalls.
// Reset: synchronous, active high; clears all valid bits and sets mono mode.
// busy is high during reset and for the cycle after it, low otherwise.
// Depends on hfrgb_pkg, hfrgb_decode, hfrgb_mul, hfrgb_round and assert_macros.svh.
`include "assert_macros.svh"

module half_float_rgb_to_gray_or_bgr8_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  hfrgb_pkg::req_type   req_data,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data,
   output logic                 rsp_valid,
   output hfrgb_pkg::rsp_type   rsp_data
);

   logic                                mono_ff, mono_in;
   logic                                busy_ff;
   logic                                accept;
   hfrgb_pkg::ctrl_type                 s1_ctrl, s2_ctrl;
   hfrgb_pkg::q16_rgb_type              s1_q;
   logic [hfrgb_pkg::PROD_WIDTH-1:0]    s2_prod_r, s2_prod_g, s2_prod_b;
   logic [hfrgb_pkg::COL_WIDTH-1:0]     s2_col_r, s2_col_g, s2_col_b;

   assign accept  = start && !busy_ff;
   assign mono_in = csr_wr_en ? csr_wr_data : mono_ff;
   assign busy    = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mono_ff <= hfrgb_pkg::MONO_RESET;
         busy_ff <= 1'b1;
      end else begin
         mono_ff <= mono_in;
         busy_ff <= 1'b0;
      end
   end

   hfrgb_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .mono     (mono_ff),
      .req_data (req_data),
      .s1_ctrl  (s1_ctrl),
      .s1_q     (s1_q)
   );

   hfrgb_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .s1_ctrl   (s1_ctrl),
      .s1_q      (s1_q),
      .s2_ctrl   (s2_ctrl),
      .s2_prod_r (s2_prod_r),
      .s2_prod_g (s2_prod_g),
      .s2_prod_b (s2_prod_b),
      .s2_col_r  (s2_col_r),
      .s2_col_g  (s2_col_g),
      .s2_col_b  (s2_col_b)
   );

   hfrgb_round u_round (
      .clock     (clock),
      .reset     (reset),
      .s2_ctrl   (s2_ctrl),
      .s2_prod_r (s2_prod_r),
      .s2_prod_g (s2_prod_g),
      .s2_prod_b (s2_prod_b),
      .s2_col_r  (s2_col_r),
      .s2_col_g  (s2_col_g),
      .s2_col_b  (s2_col_b),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // an accepted item enters stage one with the mode in force
   `ASSERT_NEXT(a_accept_enters, clock, reset, accept, s1_ctrl.valid && (s1_ctrl.mono == $past(mono_ff)))
   // an item in the multiply stage reaches the output through the stage three and output registers
   `ASSERT_NEXT(a_s2_advances, clock, reset, s2_ctrl.valid, ##1 rsp_valid)
   // mono results carry one byte and zero padding
   `ASSERT_SAME(a_mono_shape, clock, reset, rsp_valid && (rsp_data.byte_count == hfrgb_pkg::BYTES_MONO), (rsp_data.second_byte == 8'd0) && (rsp_data.third_byte == 8'd0))
   // every result is either mono or colour
   `ASSERT_SAME(a_count_legal, clock, reset, rsp_valid, (rsp_data.byte_count == hfrgb_pkg::BYTES_MONO) || (rsp_data.byte_count == hfrgb_pkg::BYTES_COLOUR))

endmodule

/* test/tb.sv */
// self-checking bench for half_float_rgb_to_gray_or_bgr8_core: half-float pixels in,
// grey or b/g/r bytes out, checked against an in-bench predictor
// depends on hfrgb_pkg for the item types and the byte-count codes
module tb;

   localparam logic MODE_COLOUR = 1'b0;
   localparam logic MODE_MONO   = 1'b1;

   // bt.601 weights in q0.16
   localparam logic [63:0] LUMA_R = 64'd19595;
   localparam logic [63:0] LUMA_G = 64'd38470;
   localparam logic [63:0] LUMA_B = 64'd7471;

   localparam logic [23:0] FIXED_MAX   = 24'hFF_FFFF;
   localparam int          CYCLE_LIMIT = 100000;
   localparam int          DRAIN_WAIT  = 8;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   hfrgb_pkg::req_type req_data;
   logic               csr_wr_en;
   logic               csr_wr_data;
   logic               rsp_valid;
   hfrgb_pkg::rsp_type rsp_data;

   hfrgb_pkg::rsp_type pending_bytes [$];
   logic               mode_shadow;
   logic               steady_flow;
   int                 fault_count;
   int                 cycle_count;

   half_float_rgb_to_gray_or_bgr8_core uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // half-precision pattern to unsigned q8.16, negatives and nan give zero
   function automatic logic [23:0] half_to_fixed(input logic [15:0] h);
      logic [4:0]  ex;
      logic [23:0] mant;
      int          sh;
      ex = h[14:10];
      if (h[15] || (ex == 5'h1F && h[9:0] != 10'd0)) return '0;
      if (ex == 5'h1F) return FIXED_MAX;
      mant = {13'd0, (ex != 5'd0), h[9:0]};
      // fixed value is mant * 2^(e - 9), with e = 1 for subnormals
      sh = (ex == 5'd0) ? -8 : int'(ex) - 9;
      if (sh >= 14) return FIXED_MAX;
      if (sh >= 0) return mant << sh;
      return (mant + (24'd1 << (-sh - 1))) >> (-sh);
   endfunction

   function automatic logic [7:0] channel_byte(input logic [23:0] q);
      logic [39:0] acc;
      acc = (40'(q) * 40'd255 + 40'h8000) >> 16;
      return (acc > 40'd255) ? 8'hFF : acc[7:0];
   endfunction

   function automatic hfrgb_pkg::rsp_type pixel_bytes(input hfrgb_pkg::req_type px,
                                                      input logic mode);
      logic [23:0]        r;
      logic [23:0]        g;
      logic [23:0]        b;
      logic [63:0]        acc;
      hfrgb_pkg::rsp_type res;
      r = half_to_fixed(px.red_half);
      g = half_to_fixed(px.green_half);
      b = half_to_fixed(px.blue_half);
      if (mode == MODE_MONO) begin
         acc = 64'(r) * LUMA_R + 64'(g) * LUMA_G + 64'(b) * LUMA_B;
         acc = (acc * 64'd255 + 64'h8000_0000) >> 32;
         res.first_byte  = (acc > 64'd255) ? 8'hFF : acc[7:0];
         res.second_byte = 8'd0;
         res.third_byte  = 8'd0;
         res.byte_count  = hfrgb_pkg::BYTES_MONO;
      end else begin
         res.first_byte  = channel_byte(b);
         res.second_byte = channel_byte(g);
         res.third_byte  = channel_byte(r);
         res.byte_count  = hfrgb_pkg::BYTES_COLOUR;
      end
      return res;
   endfunction

   function automatic logic [15:0] special_half(input int unsigned k);
      case (k % 20)
         0:       return 16'h0000; // positive zero
         1:       return 16'h8000; // negative zero
         2:       return 16'h0001; // smallest subnormal
         3:       return 16'h0080; // subnormal exactly half an lsb of q8.16
         4:       return 16'h007F; // just under that tie
         5:       return 16'h03FF; // largest subnormal
         6:       return 16'h0400; // smallest normal
         7:       return 16'h3800; // 0.5
         8:       return 16'h3C00; // 1.0
         9:       return 16'h3BFF; // just under 1.0
         10:      return 16'h4000; // 2.0
         11:      return 16'h5BFF; // largest value under 256
         12:      return 16'h5C00; // 256, first saturating value
         13:      return 16'h7BFF; // largest finite
         14:      return 16'h7C00; // +inf
         15:      return 16'hFC00; // -inf
         16:      return 16'h7E00; // quiet nan
         17:      return 16'h7C01; // signalling nan
         18:      return 16'hFFFF; // negative nan
         default: return 16'hBC00; // -1.0
      endcase
   endfunction

   function automatic logic [15:0] random_half();
      logic [15:0] h;
      h = 16'($urandom);
      case ($urandom_range(9))
         0, 1, 2, 3: ;
         4, 5, 6: begin
            // positive values below 2.0, subnormals included
            h[15]    = 1'b0;
            h[14:10] = 5'($urandom_range(15));
         end
         7: begin
            h[15]    = 1'b0;
            h[14:10] = 5'($urandom_range(14, 23));
         end
         8:       h[15:10] = 6'd0;
         default: h = special_half($urandom_range(19));
      endcase
      return h;
   endfunction

   task automatic report_fault(input string what, input hfrgb_pkg::rsp_type want,
                               input hfrgb_pkg::rsp_type got);
      fault_count++;
      if (fault_count <= 10)
         $display("%s: expected %02h %02h %02h n=%0d, got %02h %02h %02h n=%0d", what,
                  want.first_byte, want.second_byte, want.third_byte, want.byte_count,
                  got.first_byte, got.second_byte, got.third_byte, got.byte_count);
   endtask

   task automatic send_pixel(input hfrgb_pkg::req_type px);
      if (!steady_flow && $urandom_range(99) < 20) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= px;
      // busy seen here is the value the block sampled at this edge
      do @(posedge clock); while (busy);
      pending_bytes.push_back(pixel_bytes(px, mode_shadow));
   endtask

   task automatic write_mode(input logic mode);
      start <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      mode_shadow = mode;
   endtask

   task automatic send_edge_set(input int unsigned r_ofs, input int unsigned g_ofs,
                                input int unsigned b_ofs);
      hfrgb_pkg::req_type px;
      for (int unsigned i = 0; i < 10; i++) begin
         px.red_half   = special_half(2 * i + r_ofs);
         px.green_half = special_half(2 * i + g_ofs);
         px.blue_half  = special_half(2 * i + b_ofs);
         send_pixel(px);
      end
   endtask

   // no write first, so this also checks that reset leaves mono mode on
   task automatic test_mono_edges();
      hfrgb_pkg::req_type px;
      send_edge_set(0, 1, 7);
      px = '{16'h3C00, 16'h3C00, 16'h3C00};
      send_pixel(px);
      px = '{16'h7C00, 16'h7C00, 16'h7C00};
      send_pixel(px);
   endtask

   task automatic test_colour_edges();
      write_mode(MODE_COLOUR);
      send_edge_set(1, 0, 13);
      // an all-ones red, the largest finite green and the largest blue under 256, in colour mode
      send_pixel('{16'hFFFF, 16'h7BFF, 16'h5BFF});
   endtask

   task automatic test_random_traffic();
      hfrgb_pkg::req_type px;
      logic               phase_mode [6] = '{MODE_MONO, MODE_COLOUR, MODE_MONO,
                                             MODE_COLOUR, MODE_COLOUR, MODE_MONO};
      for (int p = 0; p < 6; p++) begin
         write_mode(phase_mode[p]);
         steady_flow = (p == 3);
         for (int i = 0; i < 230; i++) begin
            px.red_half   = random_half();
            px.green_half = random_half();
            px.blue_half  = random_half();
            send_pixel(px);
         end
      end
      steady_flow = 1'b0;
   endtask

   always @(posedge clock) begin : check_results
      hfrgb_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_bytes.size() == 0) begin
            report_fault("result with no item pending", '0, rsp_data);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_data.first_byte !== want.first_byte
                || rsp_data.second_byte !== want.second_byte
                || rsp_data.third_byte !== want.third_byte
                || rsp_data.byte_count !== want.byte_count)
               report_fault("byte mismatch", want, rsp_data);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("half_float_rgb_to_gray_or_bgr8_core verification failed");
         $finish;
      end
   end

   initial begin
      fault_count = 0;
      cycle_count = 0;
      mode_shadow = MODE_MONO;
      steady_flow = 1'b0;
      reset       <= 1'b1;
      start       <= 1'b0;
      req_data    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_mono_edges();
      test_colour_edges();
      test_random_traffic();

      start <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fault_count == 0)
         $display("half_float_rgb_to_gray_or_bgr8_core verification clean");
      else
         $display("half_float_rgb_to_gray_or_bgr8_core verification failed");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hdl
hdl/hfrgb_pkg.sv
hdl/hfrgb_decode.sv
hdl/hfrgb_mul.sv
hdl/hfrgb_round.sv
hdl/half_float_rgb_to_gray_or_bgr8_core.sv
test/tb.sv
